// File: rtl/core/assert_macros.svh
// Concurrent assertion helpers, compiled out when NO_ASSERTIONS is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)

`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/core/spds_pkg.sv
`timescale 1ns / 1ps

package spds_pkg;

    typedef enum logic [14:0] {
        PH_IDLE       = 15'b000000000000001,
        PH_START      = 15'b000000000000010,
        PH_MOVE_FULL  = 15'b000000000000100,
        PH_HOLD_FULL  = 15'b000000000001000,
        PH_MOVE_60    = 15'b000000000010000,
        PH_HOLD_60    = 15'b000000000100000,
        PH_MOVE_40    = 15'b000000001000000,
        PH_HOLD_40    = 15'b000000010000000,
        PH_MOVE_15    = 15'b000000100000000,
        PH_HOLD_15    = 15'b000001000000000,
        PH_MOVE_ZERO  = 15'b000010000000000,
        PH_LOCK       = 15'b000100000000000,
        PH_DONE       = 15'b001000000000000,
        PH_JOG_UP     = 15'b010000000000000,
        PH_JOG_DOWN   = 15'b100000000000000
    } t_phase;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_START    = 2'd1,
        MODE_JOG_MAX  = 2'd2,
        MODE_JOG_ZERO = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_STOP  = 2'd1,
        ACT_DRIVE = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_REACHED  = 3'd1,
        EV_TIMEOUT  = 3'd2,
        EV_ACCEPT   = 3'd3,
        EV_IGNORE   = 3'd4,
        EV_COMPLETE = 3'd5
    } t_event;

    localparam logic [2:0] REG_FULL     = 3'd0;
    localparam logic [2:0] REG_SIXTY    = 3'd1;
    localparam logic [2:0] REG_FORTY    = 3'd2;
    localparam logic [2:0] REG_FIFTEEN  = 3'd3;
    localparam logic [2:0] REG_TOL      = 3'd4;
    localparam logic [2:0] REG_TIMEOUT  = 3'd5;
    localparam logic [2:0] REG_HOLD     = 3'd6;
    localparam logic [2:0] REG_DRIVE    = 3'd7;

    localparam logic [31:0] START_DELAY_MS = 32'd200;
    localparam logic [31:0] LOCK_SETTLE_MS = 32'd1500;
    localparam logic [6:0]  DRIVE_MAX      = 7'd100;

    typedef struct packed {
        logic [15:0] full_um;
        logic [15:0] sixty_um;
        logic [15:0] forty_um;
        logic [15:0] fifteen_um;
        logic [15:0] tol_um;
        logic [15:0] timeout_ms;
        logic [15:0] hold_ms;
        logic [6:0]  drive_pct;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        full_um:    16'd33623,
        sixty_um:   16'd27124,
        forty_um:   16'd17229,
        fifteen_um: 16'd6547,
        tol_um:     16'd500,
        timeout_ms: 16'd6000,
        hold_ms:    16'd3000,
        drive_pct:  7'd50
    };

    typedef struct packed {
        t_phase      phase;
        logic        load_start;
        t_action     action;
        logic [7:0]  pct;
        t_event      evt;
    } t_step;

    function automatic logic [3:0] phase_num(input t_phase ph);
        logic [3:0] num;
        case (ph)
            PH_IDLE:      num = 4'd0;
            PH_START:     num = 4'd1;
            PH_MOVE_FULL: num = 4'd2;
            PH_HOLD_FULL: num = 4'd3;
            PH_MOVE_60:   num = 4'd4;
            PH_HOLD_60:   num = 4'd5;
            PH_MOVE_40:   num = 4'd6;
            PH_HOLD_40:   num = 4'd7;
            PH_MOVE_15:   num = 4'd8;
            PH_HOLD_15:   num = 4'd9;
            PH_MOVE_ZERO: num = 4'd10;
            PH_LOCK:      num = 4'd11;
            PH_DONE:      num = 4'd12;
            PH_JOG_UP:    num = 4'd13;
            PH_JOG_DOWN:  num = 4'd14;
            default:      num = 4'd15;
        endcase
        return num;
    endfunction

endpackage

// File: rtl/core/spds_step.sv
`timescale 1ns / 1ps

module spds_step (
    input  spds_pkg::t_phase      i_phase,
    input  logic [31:0]           i_start_ms,
    input  spds_pkg::t_cfg        i_cfg,
    input  spds_pkg::t_mode       i_mode,
    input  logic [31:0]           i_now_ms,
    input  logic signed [20:0]    i_pos_um,
    output spds_pkg::t_step       o_step
);

    logic [31:0]        elapsed;
    logic [6:0]         drive_sat;
    logic [7:0]         drive_neg;
    logic [15:0]        move_tgt;
    logic signed [21:0] tgt_ext;
    logic signed [21:0] pos_ext;
    logic signed [21:0] err;
    logic [21:0]        mag;
    logic               reached;
    logic               timed_out;
    logic               move_done;
    logic               cmd_ok;
    spds_pkg::t_action  move_act;
    logic [7:0]         move_pct;
    spds_pkg::t_event   move_evt;

    always_comb begin
        elapsed   = i_now_ms - i_start_ms;
        drive_sat = (i_cfg.drive_pct > spds_pkg::DRIVE_MAX) ? spds_pkg::DRIVE_MAX
                                                             : i_cfg.drive_pct;
        drive_neg = 8'(-{2'b00, drive_sat[6:1]});

        case (i_phase)
            spds_pkg::PH_MOVE_FULL: move_tgt = i_cfg.full_um;
            spds_pkg::PH_JOG_UP:    move_tgt = i_cfg.full_um;
            spds_pkg::PH_MOVE_60:   move_tgt = i_cfg.sixty_um;
            spds_pkg::PH_MOVE_40:   move_tgt = i_cfg.forty_um;
            spds_pkg::PH_MOVE_15:   move_tgt = i_cfg.fifteen_um;
            default:                move_tgt = 16'd0;
        endcase

        tgt_ext   = {6'd0, move_tgt};
        pos_ext   = {i_pos_um[20], i_pos_um};
        err       = tgt_ext - pos_ext;
        mag       = err[21] ? 22'(-err) : err;
        reached   = mag <= {6'd0, i_cfg.tol_um};
        timed_out = elapsed >= {16'd0, i_cfg.timeout_ms};
        move_done = reached || timed_out;

        move_act = move_done ? spds_pkg::ACT_STOP : spds_pkg::ACT_DRIVE;
        if (move_done) begin
            move_pct = 8'd0;
        end else if (!err[21] && (err != 22'sd0)) begin
            move_pct = {1'b0, drive_sat};
        end else begin
            move_pct = drive_neg;
        end
        move_evt = reached ? spds_pkg::EV_REACHED
                 : timed_out ? spds_pkg::EV_TIMEOUT : spds_pkg::EV_NONE;

        cmd_ok = (i_phase == spds_pkg::PH_IDLE) || (i_phase == spds_pkg::PH_DONE);

        o_step.phase      = i_phase;
        o_step.load_start = 1'b0;
        o_step.action     = spds_pkg::ACT_NONE;
        o_step.pct        = 8'd0;
        o_step.evt        = spds_pkg::EV_NONE;

        if (i_mode != spds_pkg::MODE_TICK) begin
            if (cmd_ok) begin
                o_step.load_start = 1'b1;
                o_step.evt        = spds_pkg::EV_ACCEPT;
                case (i_mode)
                    spds_pkg::MODE_START:   o_step.phase = spds_pkg::PH_START;
                    spds_pkg::MODE_JOG_MAX: o_step.phase = spds_pkg::PH_JOG_UP;
                    default:                o_step.phase = spds_pkg::PH_JOG_DOWN;
                endcase
            end else begin
                o_step.evt = spds_pkg::EV_IGNORE;
            end
        end else begin
            case (i_phase)
                spds_pkg::PH_IDLE, spds_pkg::PH_DONE: begin
                end
                spds_pkg::PH_START: begin
                    o_step.action = spds_pkg::ACT_STOP;
                    if (elapsed >= spds_pkg::START_DELAY_MS) begin
                        o_step.phase      = spds_pkg::PH_MOVE_FULL;
                        o_step.load_start = 1'b1;
                    end
                end
                spds_pkg::PH_MOVE_FULL, spds_pkg::PH_MOVE_60, spds_pkg::PH_MOVE_40,
                spds_pkg::PH_MOVE_15, spds_pkg::PH_MOVE_ZERO: begin
                    o_step.action = move_act;
                    o_step.pct    = move_pct;
                    o_step.evt    = move_evt;
                    if (move_done) begin
                        o_step.load_start = 1'b1;
                        case (i_phase)
                            spds_pkg::PH_MOVE_FULL: o_step.phase = spds_pkg::PH_HOLD_FULL;
                            spds_pkg::PH_MOVE_60:   o_step.phase = spds_pkg::PH_HOLD_60;
                            spds_pkg::PH_MOVE_40:   o_step.phase = spds_pkg::PH_HOLD_40;
                            spds_pkg::PH_MOVE_15:   o_step.phase = spds_pkg::PH_HOLD_15;
                            default:                o_step.phase = spds_pkg::PH_LOCK;
                        endcase
                    end
                end
                spds_pkg::PH_HOLD_FULL, spds_pkg::PH_HOLD_60, spds_pkg::PH_HOLD_40,
                spds_pkg::PH_HOLD_15: begin
                    o_step.action = spds_pkg::ACT_STOP;
                    if (elapsed >= {16'd0, i_cfg.hold_ms}) begin
                        o_step.load_start = 1'b1;
                        case (i_phase)
                            spds_pkg::PH_HOLD_FULL: o_step.phase = spds_pkg::PH_MOVE_60;
                            spds_pkg::PH_HOLD_60:   o_step.phase = spds_pkg::PH_MOVE_40;
                            spds_pkg::PH_HOLD_40:   o_step.phase = spds_pkg::PH_MOVE_15;
                            default:                o_step.phase = spds_pkg::PH_MOVE_ZERO;
                        endcase
                    end
                end
                spds_pkg::PH_LOCK: begin
                    o_step.action = spds_pkg::ACT_STOP;
                    if (elapsed >= spds_pkg::LOCK_SETTLE_MS) begin
                        o_step.phase = spds_pkg::PH_DONE;
                        o_step.evt   = spds_pkg::EV_COMPLETE;
                    end
                end
                spds_pkg::PH_JOG_UP, spds_pkg::PH_JOG_DOWN: begin
                    o_step.action = move_act;
                    o_step.pct    = move_pct;
                    o_step.evt    = move_evt;
                    if (move_done) begin
                        o_step.phase = spds_pkg::PH_IDLE;
                    end
                end
                default: begin
                    o_step.action = spds_pkg::ACT_STOP;
                    o_step.phase  = spds_pkg::PH_DONE;
                end
            endcase
        end
    end

endmodule

// File: rtl/core/staged_position_deploy_sequencer_top.sv
`timescale 1ns / 1ps

// Staged deploy sequencer: each request on the slave stream is a timer tick or a command
// (tuser) with a millisecond timestamp and encoder position (tdata); each gives exactly one
// result with phase, motor action, drive percent and event. One request per clock cycle
// unless stalled: the request is captured in an input register, the step logic and the
// phase/phase-start registers update in one pass, the result lands in an output register
// that holds while the master side stalls. Configuration registers sit on the APB port at
// byte address 4*index; the user must write them only while the stream is idle (unchecked).
`include "assert_macros.svh"

module staged_position_deploy_sequencer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // now_ms[31:0], position_um[52:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // mode[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // phase[3:0], active[4], motor_action[6:5],
                                        // motor_percent[14:7], event_res[17:15], zero pad
);

    spds_pkg::t_cfg     r_cfg;
    spds_pkg::t_phase   r_phase;
    logic [31:0]        r_start_ms;

    logic               r_in_valid;
    spds_pkg::t_mode    r_in_mode;
    logic [31:0]        r_in_now;
    logic signed [20:0] r_in_pos;

    logic               r_out_valid;
    logic [23:0]        r_out_data;
    logic [23:0]        n_out_data;

    logic               cfg_wr;
    logic               advance;
    logic [3:0]         res_phase;
    logic               res_active;
    spds_pkg::t_step    step;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[4:2])
            spds_pkg::REG_FULL:    prdata = {16'd0, r_cfg.full_um};
            spds_pkg::REG_SIXTY:   prdata = {16'd0, r_cfg.sixty_um};
            spds_pkg::REG_FORTY:   prdata = {16'd0, r_cfg.forty_um};
            spds_pkg::REG_FIFTEEN: prdata = {16'd0, r_cfg.fifteen_um};
            spds_pkg::REG_TOL:     prdata = {16'd0, r_cfg.tol_um};
            spds_pkg::REG_TIMEOUT: prdata = {16'd0, r_cfg.timeout_ms};
            spds_pkg::REG_HOLD:    prdata = {16'd0, r_cfg.hold_ms};
            default:               prdata = {25'd0, r_cfg.drive_pct};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= spds_pkg::CFG_RESET;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                spds_pkg::REG_FULL:    r_cfg.full_um    <= pwdata[15:0];
                spds_pkg::REG_SIXTY:   r_cfg.sixty_um   <= pwdata[15:0];
                spds_pkg::REG_FORTY:   r_cfg.forty_um   <= pwdata[15:0];
                spds_pkg::REG_FIFTEEN: r_cfg.fifteen_um <= pwdata[15:0];
                spds_pkg::REG_TOL:     r_cfg.tol_um     <= pwdata[15:0];
                spds_pkg::REG_TIMEOUT: r_cfg.timeout_ms <= pwdata[15:0];
                spds_pkg::REG_HOLD:    r_cfg.hold_ms    <= pwdata[15:0];
                default:               r_cfg.drive_pct  <= pwdata[6:0];
            endcase
        end
    end

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_mode <= spds_pkg::t_mode'(s_axis_tuser);
            r_in_now  <= s_axis_tdata[31:0];
            r_in_pos  <= s_axis_tdata[52:32];
        end
    end

    spds_step u_step (
        .i_phase    (r_phase),
        .i_start_ms (r_start_ms),
        .i_cfg      (r_cfg),
        .i_mode     (r_in_mode),
        .i_now_ms   (r_in_now),
        .i_pos_um   (r_in_pos),
        .o_step     (step)
    );

    assign res_phase  = spds_pkg::phase_num(step.phase);
    assign res_active = (step.phase != spds_pkg::PH_IDLE) && (step.phase != spds_pkg::PH_DONE);
    assign n_out_data = {6'd0, step.evt, step.pct, step.action, res_active, res_phase};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= spds_pkg::PH_IDLE;
            r_start_ms <= 32'd0;
        end else if (advance) begin
            r_phase <= step.phase;
            if (step.load_start) begin
                r_start_ms <= r_in_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    `ASSERT_RST(a_phase_onehot, i_clk, i_rst_n, $onehot(r_phase), "phase register not one-hot")

    `ASSERT_RST(a_stall_full, i_clk, i_rst_n, !s_axis_tready |-> (r_in_valid && r_out_valid), "input stalled with free stage")

    `ASSERT_RST(a_drive_no_event, i_clk, i_rst_n, (r_out_valid && (r_out_data[6:5] == spds_pkg::ACT_DRIVE)) |-> (r_out_data[17:15] == spds_pkg::EV_NONE), "drive result carries an event")

    `ASSERT_RST(a_accept_phase, i_clk, i_rst_n, (advance && (step.evt == spds_pkg::EV_ACCEPT)) |=> ((r_phase == spds_pkg::PH_START) || (r_phase == spds_pkg::PH_JOG_UP) || (r_phase == spds_pkg::PH_JOG_DOWN)), "accepted command left wrong phase")

endmodule

// File: tb/tb_staged_position_deploy_sequencer_top.sv
`timescale 1ns / 1ps

module tb_staged_position_deploy_sequencer_top;
    import spds_pkg::*;

    localparam logic [3:0] PN_IDLE      = 4'd0;
    localparam logic [3:0] PN_START     = 4'd1;
    localparam logic [3:0] PN_MOVE_FULL = 4'd2;
    localparam logic [3:0] PN_HOLD_FULL = 4'd3;
    localparam logic [3:0] PN_MOVE_60   = 4'd4;
    localparam logic [3:0] PN_HOLD_60   = 4'd5;
    localparam logic [3:0] PN_MOVE_40   = 4'd6;
    localparam logic [3:0] PN_HOLD_40   = 4'd7;
    localparam logic [3:0] PN_MOVE_15   = 4'd8;
    localparam logic [3:0] PN_HOLD_15   = 4'd9;
    localparam logic [3:0] PN_MOVE_ZERO = 4'd10;
    localparam logic [3:0] PN_LOCK      = 4'd11;
    localparam logic [3:0] PN_DONE      = 4'd12;
    localparam logic [3:0] PN_JOG_UP    = 4'd13;
    localparam logic [3:0] PN_JOG_DOWN  = 4'd14;

    localparam int SET_RANDOM = 0;
    localparam int SET_ZERO   = 1;
    localparam int SET_MAX    = 2;
    localparam int SET_SAT    = 3;

    localparam int DIRECTED_ROWS    = 28;
    localparam int ITEMS_PER_SET    = 225;
    localparam int SET_COUNT        = 8;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int LONG_HOLD_AFTER  = 600;

    // result fields, highest bits first so the struct maps straight onto tdata
    typedef struct packed {
        t_event      evt;
        logic [7:0]  pct;
        t_action     action;
        logic        active;
        logic [3:0]  phase;
    } t_report;

    typedef struct packed {
        t_mode              mode;
        logic [31:0]        now;
        logic signed [20:0] pos;
        logic               typed;
        t_report            want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [4:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata  = '0;   // now_ms[31:0], position_um[52:32], zero pad
    logic [1:0]  s_axis_tuser  = '0;   // mode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // phase[3:0], active[4], motor_action[6:5],
                                       // motor_percent[14:7], event_res[17:15], zero pad

    staged_position_deploy_sequencer_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    logic [3:0]  seq_phase    = PN_IDLE;
    logic [31:0] seq_start_ms = '0;
    logic [15:0] cfg_reg [8];

    t_report expected_reports [$];
    int      fault_count  = 0;
    int      reports_seen = 0;
    int      quiet_cycles = 0;
    int      burst_left   = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int target_of(logic [3:0] ph);
        case (ph)
            PN_MOVE_FULL, PN_JOG_UP: return int'(cfg_reg[REG_FULL]);
            PN_MOVE_60:              return int'(cfg_reg[REG_SIXTY]);
            PN_MOVE_40:              return int'(cfg_reg[REG_FORTY]);
            PN_MOVE_15:              return int'(cfg_reg[REG_FIFTEEN]);
            default:                 return 0;
        endcase
    endfunction

    function automatic t_report advance_sequencer(t_mode mode, logic [31:0] now,
                                                  logic signed [20:0] pos);
        t_report     r;
        logic [3:0]  ph;
        logic [31:0] elapsed;
        int          err;
        int          mag;
        int          drive;
        bit          fin;
        r       = '0;
        ph      = seq_phase;
        elapsed = now - seq_start_ms;
        fin     = 1'b0;
        if (mode != MODE_TICK) begin
            if (ph == PN_IDLE || ph == PN_DONE) begin
                ph = (mode == MODE_START) ? PN_START :
                     (mode == MODE_JOG_MAX) ? PN_JOG_UP : PN_JOG_DOWN;
                seq_start_ms = now;
                r.evt = EV_ACCEPT;
            end else begin
                r.evt = EV_IGNORE;
            end
        end else begin
            case (ph)
                PN_IDLE, PN_DONE: ;
                PN_START: begin
                    r.action = ACT_STOP;
                    if (elapsed >= START_DELAY_MS) begin
                        ph = PN_MOVE_FULL;
                        seq_start_ms = now;
                    end
                end
                PN_MOVE_FULL, PN_MOVE_60, PN_MOVE_40, PN_MOVE_15, PN_MOVE_ZERO,
                PN_JOG_UP, PN_JOG_DOWN: begin
                    err   = target_of(ph) - int'(pos);
                    mag   = (err < 0) ? -err : err;
                    drive = int'(cfg_reg[REG_DRIVE][6:0]);
                    if (drive > 100) drive = 100;
                    if (mag <= int'(cfg_reg[REG_TOL])) begin
                        r.action = ACT_STOP;
                        r.evt    = EV_REACHED;
                        fin      = 1'b1;
                    end else if (elapsed >= {16'h0, cfg_reg[REG_TIMEOUT]}) begin
                        r.action = ACT_STOP;
                        r.evt    = EV_TIMEOUT;
                        fin      = 1'b1;
                    end else begin
                        r.action = ACT_DRIVE;
                        r.pct    = 8'((err > 0) ? drive : -(drive / 2));
                    end
                    if (fin) begin
                        if (ph == PN_JOG_UP || ph == PN_JOG_DOWN) begin
                            ph = PN_IDLE;
                        end else begin
                            ph = ph + 4'd1;
                            seq_start_ms = now;
                        end
                    end
                end
                PN_HOLD_FULL, PN_HOLD_60, PN_HOLD_40, PN_HOLD_15: begin
                    r.action = ACT_STOP;
                    if (elapsed >= {16'h0, cfg_reg[REG_HOLD]}) begin
                        ph = ph + 4'd1;
                        seq_start_ms = now;
                    end
                end
                PN_LOCK: begin
                    r.action = ACT_STOP;
                    if (elapsed >= LOCK_SETTLE_MS) begin
                        ph    = PN_DONE;
                        r.evt = EV_COMPLETE;
                    end
                end
                default: begin
                    r.action = ACT_STOP;
                    ph = PN_DONE;
                end
            endcase
        end
        seq_phase = ph;
        r.phase   = ph;
        r.active  = (ph != PN_IDLE && ph != PN_DONE);
        return r;
    endfunction

    function automatic t_row typed_row(t_mode mode, logic [31:0] now, int pos,
                                       logic [3:0] ph, t_action act, int pct, t_event ev);
        t_row r;
        r.mode        = mode;
        r.now         = now;
        r.pos         = 21'(pos);
        r.typed       = 1'b1;
        r.want.phase  = ph;
        r.want.active = (ph != PN_IDLE && ph != PN_DONE);
        r.want.action = act;
        r.want.pct    = 8'(pct);
        r.want.evt    = ev;
        return r;
    endfunction

    function automatic t_row free_row(t_mode mode, logic [31:0] now, int pos);
        t_row r;
        r.mode  = mode;
        r.now   = now;
        r.pos   = 21'(pos);
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    task automatic offer(input t_mode mode, input logic [31:0] now,
                         input logic signed [20:0] pos, input bit typed, input t_report want);
        t_report predicted;
        int      gap;
        predicted = advance_sequencer(mode, now, pos);
        expected_reports.push_back(typed ? want : predicted);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {3'b000, pos, now};
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_reg[idx] = (idx == REG_DRIVE) ? {9'h0, value[6:0]} : value;
    endtask

    task automatic load_settings(input int kind);
        logic [15:0] v [8];
        for (int i = 0; i < 4; i++) begin
            v[i] = ($urandom_range(0, 15) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40000));
        end
        v[REG_TOL]     = 16'($urandom_range(0, 1500));
        v[REG_TIMEOUT] = 16'($urandom_range(300, 8000));
        v[REG_HOLD]    = 16'($urandom_range(0, 4000));
        v[REG_DRIVE]   = 16'($urandom_range(0, 127));
        case (kind)
            SET_ZERO: for (int i = 0; i < 8; i++) v[i] = 16'h0000;
            SET_MAX:  for (int i = 0; i < 8; i++) v[i] = 16'hFFFF;
            SET_SAT:  v[REG_DRIVE] = 16'd101;
            default: ;
        endcase
        for (int i = 0; i < 8; i++) write_register(3'(i), v[i]);
    endtask

    always @(posedge i_clk) begin
        t_report got;
        t_report want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_report'(m_axis_tdata[17:0]);
            reports_seen++;
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected result, got ph %0d act %0d mot %0d pct %0d ev %0d",
                         $time, got.phase, got.active, got.action, $signed(got.pct),
                         got.evt);
                fault_count++;
            end else begin
                want = expected_reports.pop_front();
                if (got.phase !== want.phase || got.active !== want.active ||
                    got.action !== want.action || got.pct !== want.pct ||
                    got.evt !== want.evt) begin
                    $display("%0t: mismatch, expected ph %0d act %0d mot %0d pct %0d ev %0d",
                             $time, want.phase, want.active, want.action,
                             $signed(want.pct), want.evt);
                    $display("%0t:           got ph %0d act %0d mot %0d pct %0d ev %0d",
                             $time, got.phase, got.active, got.action,
                             $signed(got.pct), got.evt);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_staged_position_deploy_sequencer_top: done, errors");
            $finish;
        end
    end

    initial begin
        int style;
        int period;
        int left;
        int hold_left;
        int cyc;
        bit held;
        style     = 0;
        period    = 2;
        left      = 0;
        hold_left = 0;
        cyc       = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held && reports_seen >= LONG_HOLD_AFTER) begin
                held      = 1'b1;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (left == 0) begin
                    style  = $urandom_range(0, 3);
                    period = $urandom_range(2, 7);
                    left   = $urandom_range(20, 200);
                end
                left--;
                case (style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (cyc % period) != 0;
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
            cyc++;
        end
    end

    initial begin
        t_row               directed_rows [DIRECTED_ROWS];
        int                 schedule [SET_COUNT];
        logic [31:0]        clock_ms;
        int                 counted;
        int                 pick;
        int                 tgt;
        int                 tol;
        int                 pos_i;
        int                 span;
        t_mode              mode;
        bit                 ignored;

        directed_rows = '{
            typed_row(MODE_TICK,     32'd0,     0,      PN_IDLE,    ACT_NONE,  0,   EV_NONE),
            typed_row(MODE_JOG_MAX,  32'd100,   0,      PN_JOG_UP,  ACT_NONE,  0,   EV_ACCEPT),
            typed_row(MODE_START,    32'd100,   0,      PN_JOG_UP,  ACT_NONE,  0,   EV_IGNORE),
            typed_row(MODE_TICK,     32'd101,   0,      PN_JOG_UP,  ACT_DRIVE, 50,  EV_NONE),
            typed_row(MODE_TICK,     32'd102,   34123,  PN_IDLE,    ACT_STOP,  0,   EV_REACHED),
            typed_row(MODE_JOG_ZERO, 32'd200,   0,      PN_JOG_DOWN, ACT_NONE, 0,   EV_ACCEPT),
            typed_row(MODE_TICK,     32'd201,   1000,   PN_JOG_DOWN, ACT_DRIVE, -25, EV_NONE),
            typed_row(MODE_TICK,     32'd6200,  1000,   PN_IDLE,    ACT_STOP,  0,   EV_TIMEOUT),
            free_row(MODE_START,     32'hFFFF_FF00, -1048576),
            free_row(MODE_TICK,      32'hFFFF_FFC7, 0),
            free_row(MODE_TICK,      32'd8,     0),
            free_row(MODE_TICK,      32'd20,    1048575),
            free_row(MODE_TICK,      32'd30,    -1048576),
            free_row(MODE_TICK,      32'd40,    33623),
            free_row(MODE_TICK,      32'd3039,  0),
            free_row(MODE_TICK,      32'd3040,  0),
            free_row(MODE_TICK,      32'd9040,  27124),
            free_row(MODE_TICK,      32'd12040, 0),
            free_row(MODE_TICK,      32'd18040, 0),
            free_row(MODE_TICK,      32'd21040, 0),
            free_row(MODE_TICK,      32'd21041, 6046),
            free_row(MODE_TICK,      32'd21042, 7047),
            free_row(MODE_TICK,      32'd24042, 0),
            free_row(MODE_TICK,      32'd24043, 0),
            typed_row(MODE_START,    32'd24044, 0,      PN_LOCK,    ACT_NONE,  0,   EV_IGNORE),
            free_row(MODE_TICK,      32'd25542, 0),
            typed_row(MODE_TICK,     32'd25543, 0,      PN_DONE,    ACT_STOP,  0,   EV_COMPLETE),
            free_row(MODE_START,     32'd25600, 0)
        };
        schedule = '{SET_RANDOM, SET_ZERO, SET_RANDOM, SET_MAX, SET_SAT,
                     SET_RANDOM, SET_RANDOM, SET_RANDOM};

        cfg_reg[REG_FULL]    = CFG_RESET.full_um;
        cfg_reg[REG_SIXTY]   = CFG_RESET.sixty_um;
        cfg_reg[REG_FORTY]   = CFG_RESET.forty_um;
        cfg_reg[REG_FIFTEEN] = CFG_RESET.fifteen_um;
        cfg_reg[REG_TOL]     = CFG_RESET.tol_um;
        cfg_reg[REG_TIMEOUT] = CFG_RESET.timeout_ms;
        cfg_reg[REG_HOLD]    = CFG_RESET.hold_ms;
        cfg_reg[REG_DRIVE]   = {9'h0, CFG_RESET.drive_pct};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            offer(directed_rows[i].mode, directed_rows[i].now, directed_rows[i].pos,
                  directed_rows[i].typed, directed_rows[i].want);
        end
        drain();

        for (int s = 0; s < SET_COUNT; s++) begin
            load_settings(schedule[s]);
            clock_ms = $urandom();
            counted  = 0;
            while (counted < ITEMS_PER_SET) begin
                pick = $urandom_range(0, 99);
                if (seq_phase == PN_IDLE || seq_phase == PN_DONE) begin
                    mode = (pick < 40) ? MODE_START : (pick < 55) ? MODE_JOG_MAX :
                           (pick < 70) ? MODE_JOG_ZERO : MODE_TICK;
                end else begin
                    mode = (pick < 6) ? t_mode'($urandom_range(1, 3)) : MODE_TICK;
                end
                ignored = (mode != MODE_TICK) && seq_phase != PN_IDLE && seq_phase != PN_DONE;

                // advance the clock; now and then jump, wrap or step back
                span = int'(cfg_reg[REG_TIMEOUT]);
                if (int'(cfg_reg[REG_HOLD]) > span) span = int'(cfg_reg[REG_HOLD]);
                if (span < 1500) span = 1500;
                span = span / 3 + 50;
                pick = $urandom_range(0, 299);
                if (pick < 6) clock_ms = $urandom();
                else if (pick < 8) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                else if (pick < 80) clock_ms = clock_ms + $urandom_range(0, 20);
                else clock_ms = clock_ms + $urandom_range(0, span);

                // place the encoder near the live target most of the time
                tgt  = target_of(seq_phase);
                tol  = int'(cfg_reg[REG_TOL]);
                pick = $urandom_range(0, 99);
                if (pick < 35) begin
                    pos_i = tgt + int'($urandom_range(0, 2 * tol)) - tol;
                end else if (pick < 45) begin
                    pos_i = tol + int'($urandom_range(0, 1));
                    pos_i = ($urandom_range(0, 1) == 1) ? tgt + pos_i : tgt - pos_i;
                end else if (pick < 80) begin
                    pos_i = tgt + int'($urandom_range(0, 40000)) - 20000;
                end else begin
                    pos_i = int'($urandom());
                end

                offer(mode, clock_ms, 21'(pos_i), 1'b0, '0);
                if (!ignored) counted++;
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("tb_staged_position_deploy_sequencer_top: done, clean");
        end else begin
            $display("tb_staged_position_deploy_sequencer_top: done, errors");
        end
        $finish;
    end

endmodule
